FILE: rtl/composite_bezier_evaluator_top_assert.svh
// assertion macros for the bezier evaluator
// used by the top level only, needs nothing else
`ifndef COMPOSITE_BEZIER_EVALUATOR_TOP_ASSERT_SVH
`define COMPOSITE_BEZIER_EVALUATOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define CBEZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbez check failed");

// condition implies consequence in the next cycle
`define CBEZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbez check failed");

`endif

FILE: rtl/cbez_pkg.sv
// types, constants and fixed point helpers for the bezier evaluator
// no dependencies
package cbez_pkg;

  localparam int CRD_BITS = 32;
  localparam int CW       = 40;        // internal signed width
  localparam int PW       = CW + 18;   // product width
  localparam int NSTG     = 9;         // pipeline register stages

  typedef logic signed [CRD_BITS-1:0] coord_t;
  typedef logic signed [CW-1:0]       wide_t;
  typedef logic signed [PW-1:0]       prod_t;
  typedef logic [16:0]                frac_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    coord_t tx;
    coord_t ty;
    coord_t tz;
  } row_t;

  localparam frac_t ONE_Q16  = 17'h10000;
  localparam prod_t HALF_LSB = prod_t'(32768);
  localparam wide_t SAT_HI   = wide_t'(64'sh7FFF_FFFF);
  localparam wide_t SAT_LO   = -wide_t'(64'sh8000_0000);

  // x times local t
  function automatic prod_t mul_u(input wide_t x, input frac_t u);
    prod_t p;
    p = prod_t'(x) * prod_t'($signed({1'b0, u}));
    return p;
  endfunction

  // a plus product scaled by 2^-16, ties toward plus infinity
  function automatic wide_t rnd_add(input wide_t a, input prod_t p);
    prod_t s;
    s = (p + HALF_LSB) >>> 16;
    return a + wide_t'(s);
  endfunction

  // clamp to signed 32 bits
  function automatic coord_t sat32(input wide_t v);
    coord_t r;
    if (v > SAT_HI) begin
      r = coord_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = coord_t'(SAT_LO);
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/cbez_table.sv
// control point memory: one write port, two registered read ports
// depends on cbez_pkg for the row type
module cbez_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cbez_pkg::row_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr_a,
  input  logic [AW-1:0]   rd_addr_b,
  output cbez_pkg::row_t  rd_data_a,
  output cbez_pkg::row_t  rd_data_b
);
  import cbez_pkg::*;

  row_t mem [DEPTH];
  row_t rd_a_r;
  row_t rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

FILE: rtl/cbez_axis.sv
// one coordinate axis of the segment evaluation, stages two to nine
// depends on cbez_pkg for widths and fixed point helpers
module cbez_axis (
  input  logic                        clk,
  input  logic [cbez_pkg::NSTG:2]     en,
  input  cbez_pkg::coord_t            p0,
  input  cbez_pkg::coord_t            t0,
  input  cbez_pkg::coord_t            p1,
  input  cbez_pkg::coord_t            t1,
  input  cbez_pkg::frac_t             u1,
  output cbez_pkg::coord_t            pos,
  output cbez_pkg::coord_t            der1,
  output cbez_pkg::coord_t            der2
);
  import cbez_pkg::*;

  wide_t a2_r, b2_r, c2_r, e0_2_r, e1_2_r, e2_2_r;
  frac_t u2_r, u3_r, u4_r, u5_r, u6_r, u7_r;
  wide_t a3_r, b3_r, c3_r, e0_3_r, e1_3_r, f0_3_r, f1_3_r;
  prod_t pe0_r, pe1_r, pe2_r;
  wide_t q0_4_r, q1_4_r, q2_4_r, e0_4_r, e1_4_r, f0_4_r, h4_r;
  prod_t pf0_r, pf1_r;
  wide_t s0_nxt, s1_nxt;
  wide_t s0_5_r, q0_5_r, q1_5_r, f0_5_r, dq0_5_r, dq1_5_r, ds5_r;
  prod_t ph_r;
  wide_t k6_r, s0_6_r, q0_6_r, q1_6_r;
  prod_t pdq0_r, pdq1_r, pds_r;
  wide_t r0_nxt, r1_nxt;
  wide_t r0_7_r, dr7_r, s7_r, k7_r;
  wide_t r0_8_r;
  prod_t pdr_r;
  coord_t der1_8_r, der2_8_r;
  coord_t pos_9_r, der1_9_r, der2_9_r;

  // stage 2: inner bezier points and first differences
  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2_r   <= wide_t'(p0);
      b2_r   <= wide_t'(p0) + wide_t'(t0);
      c2_r   <= wide_t'(p1) - wide_t'(t1);
      e0_2_r <= wide_t'(t0);
      e1_2_r <= wide_t'(p1) - wide_t'(p0) - wide_t'(t0) - wide_t'(t1);
      e2_2_r <= wide_t'(t1);
      u2_r   <= u1;
    end
  end

  // stage 3: second differences, first level products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      f0_3_r <= e1_2_r - e0_2_r;
      f1_3_r <= e2_2_r - e1_2_r;
      pe0_r  <= mul_u(e0_2_r, u2_r);
      pe1_r  <= mul_u(e1_2_r, u2_r);
      pe2_r  <= mul_u(e2_2_r, u2_r);
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
      e0_3_r <= e0_2_r;
      e1_3_r <= e1_2_r;
      u3_r   <= u2_r;
    end
  end

  // stage 4: first level points, slope products, bend difference
  always_ff @(posedge clk) begin
    if (en[4]) begin
      q0_4_r <= rnd_add(a3_r, pe0_r);
      q1_4_r <= rnd_add(b3_r, pe1_r);
      q2_4_r <= rnd_add(c3_r, pe2_r);
      pf0_r  <= mul_u(f0_3_r, u3_r);
      pf1_r  <= mul_u(f1_3_r, u3_r);
      h4_r   <= f1_3_r - f0_3_r;
      e0_4_r <= e0_3_r;
      e1_4_r <= e1_3_r;
      f0_4_r <= f0_3_r;
      u4_r   <= u3_r;
    end
  end

  // stage 5: slope first level, second level differences
  always_comb begin
    s0_nxt = rnd_add(e0_4_r, pf0_r);
    s1_nxt = rnd_add(e1_4_r, pf1_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s0_5_r  <= s0_nxt;
      ds5_r   <= s1_nxt - s0_nxt;
      dq0_5_r <= q1_4_r - q0_4_r;
      dq1_5_r <= q2_4_r - q1_4_r;
      ph_r    <= mul_u(h4_r, u4_r);
      q0_5_r  <= q0_4_r;
      q1_5_r  <= q1_4_r;
      f0_5_r  <= f0_4_r;
      u5_r    <= u4_r;
    end
  end

  // stage 6: bend value, second level products
  always_ff @(posedge clk) begin
    if (en[6]) begin
      k6_r   <= rnd_add(f0_5_r, ph_r);
      pdq0_r <= mul_u(dq0_5_r, u5_r);
      pdq1_r <= mul_u(dq1_5_r, u5_r);
      pds_r  <= mul_u(ds5_r, u5_r);
      s0_6_r <= s0_5_r;
      q0_6_r <= q0_5_r;
      q1_6_r <= q1_5_r;
      u6_r   <= u5_r;
    end
  end

  // stage 7: second level points and slope
  always_comb begin
    r0_nxt = rnd_add(q0_6_r, pdq0_r);
    r1_nxt = rnd_add(q1_6_r, pdq1_r);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      r0_7_r <= r0_nxt;
      dr7_r  <= r1_nxt - r0_nxt;
      s7_r   <= rnd_add(s0_6_r, pds_r);
      k7_r   <= k6_r;
      u7_r   <= u6_r;
    end
  end

  // stage 8: last position product, scaled derivatives
  always_ff @(posedge clk) begin
    if (en[8]) begin
      pdr_r    <= mul_u(dr7_r, u7_r);
      r0_8_r   <= r0_7_r;
      der1_8_r <= sat32((s7_r <<< 1) + s7_r);
      der2_8_r <= sat32((k7_r <<< 2) + (k7_r <<< 1));
    end
  end

  // stage 9: position
  always_ff @(posedge clk) begin
    if (en[9]) begin
      pos_9_r  <= sat32(rnd_add(r0_8_r, pdr_r));
      der1_9_r <= der1_8_r;
      der2_9_r <= der2_8_r;
    end
  end

  assign pos  = pos_9_r;
  assign der1 = der1_9_r;
  assign der2 = der2_9_r;

endmodule

FILE: rtl/composite_bezier_evaluator_top.sv
// Composite cubic bezier spline evaluator, top level.
// Input channel (in_valid / in_stall): a load word (in_mode 0) writes one control
// point with position and tangent into the table; an evaluate word (in_mode 1)
// gives a global parameter in Q1.16, clamped to 1.0, and yields one result word.
// Result channel (out_valid / out_stall): position, first and second derivative
// with respect to local t, signed Q16.16, saturated; out_ok low with all zeros
// when fewer than two points are in use.
// Config channel (cfg_valid / cfg_ready): point count, to be written only while idle;
// the user must keep to this, the block does not enforce it. One word is taken per
// cycle while in_stall is low. The segment is found and both table rows are read
// at the input edge, then eight register stages of multiply and round finish the
// curve; out_valid is the valid bit of the last stage.
// Loads take effect at once for every later evaluate word.
// A stalled receiver stops only the stages behind a full one; empty stages keep
// filling, so words are still taken until the pipeline is full.
// Reset clears valid bits and the point count; table contents are undefined
// until written.
module composite_bezier_evaluator_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_mode,
  input  logic [5:0]               in_point_index,
  input  cbez_pkg::coord_t         in_pos_x,
  input  cbez_pkg::coord_t         in_pos_y,
  input  cbez_pkg::coord_t         in_pos_z,
  input  cbez_pkg::coord_t         in_tan_x,
  input  cbez_pkg::coord_t         in_tan_y,
  input  cbez_pkg::coord_t         in_tan_z,
  input  logic [16:0]              in_curve_param,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_ok,
  output cbez_pkg::coord_t         out_point_x,
  output cbez_pkg::coord_t         out_point_y,
  output cbez_pkg::coord_t         out_point_z,
  output cbez_pkg::coord_t         out_slope_x,
  output cbez_pkg::coord_t         out_slope_y,
  output cbez_pkg::coord_t         out_slope_z,
  output cbez_pkg::coord_t         out_bend_x,
  output cbez_pkg::coord_t         out_bend_y,
  output cbez_pkg::coord_t         out_bend_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [6:0]               cfg_point_count
);
  import cbez_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int AL = NW + 17;

  logic [6:0]      count_r;
  logic [NSTG:1]   v_r;
  logic [NSTG:1]   ok_r;
  logic [NSTG+1:1] ready;
  logic            in_acc;
  logic            eval_acc;
  logic            ld_en;

  logic [NW-1:0]   n_cnt;
  logic [NW-1:0]   nm1;
  frac_t           t_cl;
  logic [AL-1:0]   alpha;
  logic [NW:0]     seg;
  frac_t           u_nxt;
  logic            ok_nxt;
  logic [AW-1:0]   addr_a;
  logic [AW-1:0]   addr_b;
  frac_t           u1_r;

  row_t            wr_row;
  row_t            row_a;
  row_t            row_b;

  coord_t          pos_x, pos_y, pos_z;
  coord_t          d1_x, d1_y, d1_z;
  coord_t          d2_x, d2_y, d2_z;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_point_count;
    end
  end

  // stage ready chain, a stage moves when it is empty or its follower moves
  always_comb begin
    ready[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      ready[k] = !v_r[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[1];
  assign in_acc   = in_valid && ready[1];
  assign eval_acc = in_acc && (in_mode == MODE_EVAL);
  assign ld_en    = in_acc && (in_mode == MODE_LOAD) &&
                    (32'(in_point_index) < MAX_POINTS);

  // valid and ok bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ready[1]) begin
        v_r[1] <= eval_acc;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ready[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      ok_r[1] <= ok_nxt;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (ready[k]) begin
        ok_r[k] <= ok_r[k-1];
      end
    end
  end

  // segment select and local t
  always_comb begin
    if (32'(count_r) > MAX_POINTS) begin
      n_cnt = NW'(MAX_POINTS);
    end else begin
      n_cnt = NW'(count_r);
    end
    ok_nxt = (n_cnt >= NW'(2));
    nm1    = n_cnt - NW'(1);
    t_cl   = (in_curve_param > ONE_Q16) ? ONE_Q16 : in_curve_param;
    alpha  = AL'(nm1) * AL'(t_cl);
    seg    = alpha[AL-1:16];
    u_nxt  = {1'b0, alpha[15:0]};
    if (seg >= (NW+1)'(nm1)) begin
      seg   = (NW+1)'(n_cnt) - (NW+1)'(2);
      u_nxt = ONE_Q16;
    end
    addr_a = AW'(seg);
    addr_b = AW'(seg + (NW+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      u1_r <= u_nxt;
    end
  end

  // control point table
  assign wr_row = '{px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                    tx: in_tan_x, ty: in_tan_y, tz: in_tan_z};

  cbez_table #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .wr_en     (ld_en),
    .wr_addr   (AW'(in_point_index)),
    .wr_data   (wr_row),
    .rd_en     (ready[1]),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (row_a),
    .rd_data_b (row_b)
  );

  // one evaluation lane per axis
  cbez_axis u_axis_x (
    .clk (clk), .en (ready[NSTG:2]),
    .p0 (row_a.px), .t0 (row_a.tx), .p1 (row_b.px), .t1 (row_b.tx), .u1 (u1_r),
    .pos (pos_x), .der1 (d1_x), .der2 (d2_x)
  );

  cbez_axis u_axis_y (
    .clk (clk), .en (ready[NSTG:2]),
    .p0 (row_a.py), .t0 (row_a.ty), .p1 (row_b.py), .t1 (row_b.ty), .u1 (u1_r),
    .pos (pos_y), .der1 (d1_y), .der2 (d2_y)
  );

  cbez_axis u_axis_z (
    .clk (clk), .en (ready[NSTG:2]),
    .p0 (row_a.pz), .t0 (row_a.tz), .p1 (row_b.pz), .t1 (row_b.tz), .u1 (u1_r),
    .pos (pos_z), .der1 (d1_z), .der2 (d2_z)
  );

  // result word, zeros when too few points
  assign out_valid   = v_r[NSTG];
  assign out_ok      = ok_r[NSTG];
  assign out_point_x = ok_r[NSTG] ? pos_x : '0;
  assign out_point_y = ok_r[NSTG] ? pos_y : '0;
  assign out_point_z = ok_r[NSTG] ? pos_z : '0;
  assign out_slope_x = ok_r[NSTG] ? d1_x : '0;
  assign out_slope_y = ok_r[NSTG] ? d1_y : '0;
  assign out_slope_z = ok_r[NSTG] ? d1_z : '0;
  assign out_bend_x  = ok_r[NSTG] ? d2_x : '0;
  assign out_bend_y  = ok_r[NSTG] ? d2_y : '0;
  assign out_bend_z  = ok_r[NSTG] ? d2_z : '0;

  // checks
`include "composite_bezier_evaluator_top_assert.svh"

  `CBEZ_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, (&v_r) && out_stall)
  `CBEZ_ASSERT_NEXT(a_hold_last, clk, rst_n, v_r[NSTG] && out_stall, v_r[NSTG])
  `CBEZ_ASSERT_NOW(a_ok_count, clk, rst_n, out_valid && out_ok, count_r >= 7'd2)

endmodule
